// ===== rtl/core/qba_pkg.sv =====
// qba_pkg: types, codes and constants of the qubit burst allocator
// no dependencies
package qba_pkg;
    localparam int NumQnicsDef = 8;
    localparam int QubitsDef   = 64;
    localparam int LogDepth    = 64;

    localparam logic [1:0] FUNC_SHOOT  = 2'd0;
    localparam logic [1:0] FUNC_RESULT = 2'd1;
    localparam logic [1:0] FUNC_CLOSE  = 2'd2;

    localparam logic [1:0] KIND_EMIT   = 2'd0;
    localparam logic [1:0] KIND_RESULT = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    localparam logic [1:0] PULSE_MID   = 2'd0;
    localparam logic [1:0] PULSE_BEGIN = 2'd1;
    localparam logic [1:0] PULSE_END   = 2'd2;
    localparam logic [1:0] PULSE_BOTH  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_LOG  = 2'd1;
    localparam logic [1:0] ST_DBL_FREE = 2'd2;

    localparam logic REG_QUBITS_IN_USE = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  qnic;
        logic [15:0] trial;
        logic        first_shot;
        logic [5:0]  shot_index;
        logic        failed;
        logic [6:0]  reported_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  qubit;
        logic [1:0]  pulse;
        logic        succeeded;
        logic [6:0]  freed_count;
        logic [15:0] trial_now;
        logic [1:0]  status;
    } t_out_item;
endpackage

// ===== rtl/core/qba_if.sv =====
// qba_in_if / qba_out_if: valid-ready channels for items and results
// depends on qba_pkg
interface qba_in_if;
    logic valid;
    logic ready;
    qba_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qba_out_if;
    logic valid;
    logic ready;
    qba_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/qba_front.sv =====
// qba_front: accepts items, drops out-of-range ones, two-entry queue to back
// depends on qba_pkg
module qba_front #(
    parameter int NUM_QNICS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qba_in_if.sink              in_ch,
    output logic                o_q_valid,
    output qba_pkg::t_in_item   o_q_item,
    input  logic                i_q_pop
);
    import qba_pkg::*;

    t_in_item   r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push, keep;

    assign in_ch.ready = (r_cnt != 2'd2);
    // drop items for unknown interfaces or unused func
    assign keep = ({29'd0, in_ch.data.qnic} < NUM_QNICS) && (in_ch.data.func != 2'd3);
    assign push = in_ch.valid && in_ch.ready && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    // queue pointers and storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
            if (i_q_pop) r_rd <= ~r_rd;
        end
        if (push) r_q[r_rd ^ (r_cnt[0] ^ i_q_pop ? 1'b1 : 1'b0) ^ i_q_pop] <= in_ch.data;
    end
endmodule

// ===== rtl/core/qba_back.sv =====
// qba_back: executes items against busy maps, counters and shot log
// depends on qba_pkg
module qba_back #(
    parameter int NUM_QNICS       = 8,
    parameter int QUBITS_PER_QNIC = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [6:0]         i_qubits_in_use,
    input  logic               i_q_valid,
    input  qba_pkg::t_in_item  i_q_item,
    output logic               o_q_pop,
    qba_out_if.source          out_ch
);
    import qba_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_WALK, S_WAIT, S_OUT} t_state;

    t_state     r_state;
    t_in_item   r_it;
    logic [63:0] r_busy [NUM_QNICS];
    logic [15:0] r_trial [NUM_QNICS];
    logic [6:0]  r_cnt [NUM_QNICS];
    logic [5:0]  r_log [NUM_QNICS*LogDepth];
    logic [5:0]  r_rdata;
    logic [6:0]  r_idx;
    logic [6:0]  r_freed;
    logic [1:0]  r_status;
    t_out_item   r_out;
    logic        r_ov;

    localparam int QW = (NUM_QNICS > 1) ? $clog2(NUM_QNICS) : 1;
    localparam int AW = QW + 6;

    logic [QW-1:0] qi;
    logic [63:0]   usable, free_bits, low_bit, rest;
    logic [5:0]    low_k;
    logic [6:0]    n_lim;
    logic [AW-1:0] rd_addr;
    logic          shoot_ok;
    t_out_item     n_out;

    assign qi = r_it.qnic[QW-1:0];
    assign n_lim = (i_qubits_in_use > 7'(QUBITS_PER_QNIC)) ? 7'(QUBITS_PER_QNIC)
                                                           : i_qubits_in_use;
    assign usable = n_lim[6] ? '1 : ((64'd1 << n_lim[5:0]) - 64'd1);
    assign free_bits = ~r_busy[qi] & usable;
    assign low_bit = free_bits & (~free_bits + 64'd1);
    assign rest = free_bits & ~low_bit;
    always_comb begin
        low_k = '0;
        for (int k = 0; k < 64; k++) if (low_bit[k]) low_k = 6'(k);
    end
    assign shoot_ok = (r_it.trial == r_trial[qi]) && (free_bits != 64'd0) && !r_cnt[qi][6];
    assign rd_addr = (r_state == S_IDLE) ? {i_q_item.qnic[QW-1:0], i_q_item.shot_index}
                                         : {qi, r_idx[5:0]};
    // a result leaving this cycle frees the output register for the next one
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && (!r_ov || out_ch.ready);
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    // result transaction built from the current item or the finished walk
    always_comb begin
        n_out = '0;
        n_out.trial_now = r_trial[qi];
        if (r_state == S_EXEC) begin
            unique case (r_it.func)
                FUNC_SHOOT: begin
                    n_out.kind  = KIND_EMIT;
                    n_out.qubit = low_k;
                    n_out.pulse = r_it.first_shot ?
                        ((rest == 0) ? PULSE_BOTH : PULSE_BEGIN) :
                        ((rest == 0) ? PULSE_END : PULSE_MID);
                end
                FUNC_RESULT: begin
                    n_out.kind = KIND_RESULT;
                    if ({1'b0, r_it.shot_index} >= r_cnt[qi]) begin
                        n_out.status = ST_NOT_LOG;
                    end else begin
                        n_out.qubit     = r_rdata;
                        n_out.succeeded = !r_it.failed;
                        if (r_it.failed && !r_busy[qi][r_rdata]) n_out.status = ST_DBL_FREE;
                    end
                end
                default: n_out.kind = KIND_CLOSE;
            endcase
        end else begin
            n_out.kind        = KIND_CLOSE;
            n_out.freed_count = r_freed;
            n_out.status      = r_status;
        end
    end

    // shot log memory, registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_log[rd_addr];
        if (r_state == S_EXEC && r_it.func == FUNC_SHOOT && shoot_ok)
            r_log[{qi, r_cnt[qi][5:0]}] <= low_k;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < NUM_QNICS; i++) begin
                r_busy[i]  <= '0;
                r_trial[i] <= '0;
                r_cnt[i]   <= '0;
            end
        end else begin
            if (r_ov && out_ch.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_q_pop) begin
                    r_it    <= i_q_item;
                    r_state <= S_EXEC;
                end
                S_READ: r_state <= S_WALK;
                S_EXEC: begin
                    unique case (r_it.func)
                        FUNC_SHOOT: begin
                            if (shoot_ok) begin
                                r_busy[qi] <= r_busy[qi] | low_bit;
                                r_cnt[qi]  <= r_cnt[qi] + 7'd1;
                                r_out <= n_out;
                                r_ov  <= 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                        FUNC_RESULT: begin
                            r_out <= n_out;
                            r_ov  <= 1'b1;
                            if ({1'b0, r_it.shot_index} < r_cnt[qi] && r_it.failed
                                && r_busy[qi][r_rdata])
                                r_busy[qi][r_rdata] <= 1'b0;
                            r_state <= S_IDLE;
                        end
                        default: begin
                            r_trial[qi] <= r_trial[qi] + 16'd1;
                            r_freed  <= '0;
                            // missing shots: nothing to walk
                            if (r_it.reported_count > r_cnt[qi]) begin
                                r_status <= ST_NOT_LOG;
                                r_idx    <= r_cnt[qi];
                            end else begin
                                r_status <= ST_OK;
                                r_idx    <= r_it.reported_count;
                            end
                            r_state  <= S_WAIT;
                        end
                    endcase
                end
                S_WAIT: r_state <= S_READ;
                S_WALK: begin
                    // r_rdata holds log entry r_idx
                    if (r_idx >= r_cnt[qi]) begin
                        r_cnt[qi] <= '0;
                        r_out <= n_out;
                        r_state <= S_OUT;
                    end else begin
                        if (r_busy[qi][r_rdata]) begin
                            r_busy[qi][r_rdata] <= 1'b0;
                            r_freed <= r_freed + 7'd1;
                        end else r_status <= ST_DBL_FREE;
                        r_idx   <= r_idx + 7'd1;
                        r_state <= S_WAIT;
                    end
                end
                default: if (!r_ov) begin
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/qubit_burst_allocator_core.sv =====
// qubit_burst_allocator_core: back end runs one item at a time; a granted shoot or a result
// goes S_EXEC, output register; a close S_WAIT, S_READ, S_WALK (repeated per shot walked),
// S_OUT. A result held by the receiver stops the back end; the 2-entry front queue then fills
// sync active-low reset clears maps, counters, shot counts; shot log is not cleared
// depends on qba_pkg, qba_if, qba_front, qba_back
module qubit_burst_allocator_core #(
    parameter int NUM_QNICS       = qba_pkg::NumQnicsDef,
    parameter int QUBITS_PER_QNIC = qba_pkg::QubitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qba_in_if.sink      in_ch,
    qba_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qba_pkg::*;

    logic [6:0] r_qiu;
    logic       q_valid, q_pop;
    t_in_item   q_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUBITS_IN_USE) ? {25'd0, r_qiu} : 32'd0;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qiu <= 7'd64;
        else if (psel && penable && pwrite && paddr[2] == REG_QUBITS_IN_USE)
            r_qiu <= pwdata[6:0];
    end

    qba_front #(.NUM_QNICS(NUM_QNICS)) u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    qba_back #(.NUM_QNICS(NUM_QNICS), .QUBITS_PER_QNIC(QUBITS_PER_QNIC)) u_back (
        .i_clk, .i_rst_n, .i_qubits_in_use(r_qiu),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop), .out_ch
    );
endmodule

// ===== rtl/core/qba_checker.sv =====
// qba_checker: port-level checks on the allocator
// depends on qba_pkg; bound to qubit_burst_allocator_core
module qba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        ov,
    input logic        ordy,
    input qba_pkg::t_out_item od,
    input logic        pready
);
    import qba_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov && !ordy |=> ov && $stable(od)) else $error("result dropped");
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov && od.kind != KIND_EMIT |-> od.pulse == PULSE_MID) else $error("pulse");
    a_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov && od.kind != KIND_CLOSE |-> od.freed_count == 7'd0) else $error("freed");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready");
endmodule

bind qubit_burst_allocator_core qba_checker u_chk (
    .i_clk, .i_rst_n, .ov(out_ch.valid), .ordy(out_ch.ready), .od(out_ch.data), .pready
);

// ===== tb/sv/qubit_burst_allocator_core_tb.sv =====
// qubit_burst_allocator_core_tb: self-checking testbench of the qubit burst allocator
// depends on qba_pkg, qba_if and qubit_burst_allocator_core
module qubit_burst_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qba_pkg::*;

    localparam int NQ        = 8;
    localparam int DRAIN_CYC = 260;
    localparam int LIMIT_CYC = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qba_in_if  in_ch ();
    qba_out_if out_ch ();

    qubit_burst_allocator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // allocator state mirror
    logic [63:0] busy_q [NQ];
    logic [15:0] trial_q [NQ];
    int          shots_q [NQ];
    logic [5:0]  shot_log_q [NQ][64];
    int          usable_cfg;

    t_out_item   expected_q [$];
    int          errors;
    int          sent_items;
    int          n_emit, n_handled, n_closed, n_dropped;
    int          snd_idle_pct, rcv_idle_pct;
    int          rcv_hold;
    longint      cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYC) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] usable_mask();
        int n;
        n = (usable_cfg > 64) ? 64 : usable_cfg;
        if (n >= 64) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // compute the result of one item and update the mirror
    function automatic bit predict_alloc(input t_in_item it, output t_out_item r);
        logic [63:0] free_bits;
        logic [63:0] bit_m;
        int          k;
        int          freed;
        logic [1:0]  st;
        r = '0;
        if (it.func == FUNC_SHOOT) begin
            free_bits = ~busy_q[it.qnic] & usable_mask();
            if (it.trial != trial_q[it.qnic]) return 0;
            if (free_bits == 0 || shots_q[it.qnic] >= LogDepth) return 0;
            k = 0;
            while (!free_bits[k]) k++;
            busy_q[it.qnic][k] = 1'b1;
            shot_log_q[it.qnic][shots_q[it.qnic]] = k[5:0];
            shots_q[it.qnic]++;
            free_bits[k] = 1'b0;
            r.kind = KIND_EMIT;
            r.qubit = k[5:0];
            if (it.first_shot) r.pulse = (free_bits == 0) ? PULSE_BOTH : PULSE_BEGIN;
            else r.pulse = (free_bits == 0) ? PULSE_END : PULSE_MID;
            r.trial_now = trial_q[it.qnic];
            r.status = ST_OK;
            return 1;
        end
        if (it.func == FUNC_RESULT) begin
            r.kind = KIND_RESULT;
            r.trial_now = trial_q[it.qnic];
            if (int'(it.shot_index) >= shots_q[it.qnic]) begin
                r.status = ST_NOT_LOG;
                return 1;
            end
            k = shot_log_q[it.qnic][it.shot_index];
            r.qubit = k[5:0];
            if (it.failed) begin
                if (!busy_q[it.qnic][k]) r.status = ST_DBL_FREE;
                else busy_q[it.qnic][k] = 1'b0;
            end else begin
                r.succeeded = 1'b1;
            end
            return 1;
        end
        if (it.func == FUNC_CLOSE) begin
            trial_q[it.qnic] = trial_q[it.qnic] + 16'd1;
            freed = 0;
            st = ST_OK;
            if (int'(it.reported_count) > shots_q[it.qnic]) begin
                st = ST_NOT_LOG;
            end else begin
                for (int i = it.reported_count; i < shots_q[it.qnic]; i++) begin
                    bit_m = 64'd1 << shot_log_q[it.qnic][i];
                    if (busy_q[it.qnic] & bit_m) begin
                        busy_q[it.qnic] &= ~bit_m;
                        freed++;
                    end else begin
                        st = ST_DBL_FREE;
                    end
                end
            end
            shots_q[it.qnic] = 0;
            r.kind = KIND_CLOSE;
            r.freed_count = freed[6:0];
            r.trial_now = trial_q[it.qnic];
            r.status = st;
            return 1;
        end
        return 0;
    endfunction

    function automatic t_in_item mk_item(input logic [1:0] f, input int q, input int tr,
                                         input bit first, input int idx, input bit fl,
                                         input int rep);
        t_in_item it;
        it.func = f;
        it.qnic = q[2:0];
        it.trial = tr[15:0];
        it.first_shot = first;
        it.shot_index = idx[5:0];
        it.failed = fl;
        it.reported_count = rep[6:0];
        return it;
    endfunction

    // send one item; valid stays high so back-to-back items need no gap
    task automatic send_item(input t_in_item it);
        t_out_item r;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= t_in_item'($urandom);
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_items++;
        if (predict_alloc(it, r)) expected_q.push_back(r);
        else n_dropped++;
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for all results plus a margin for items that give none
    task automatic drain();
        stop_sending();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // register write followed by a read back, block idle
    task automatic write_usable(input int val);
        logic [31:0] rd;
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(4 * REG_QUBITS_IN_USE); pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        usable_cfg = val & 127;
        if (rd[6:0] != 7'(val)) report("qubits_in_use read back", rd[6:0], val & 127);
    endtask

    // result checker and receiver stall
    initial begin
        t_out_item got, want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_q.size() == 0) begin
                    report("unexpected result kind", got.kind, -1);
                end else begin
                    want = expected_q.pop_front();
                    case (want.kind)
                        KIND_EMIT: n_emit++;
                        KIND_RESULT: n_handled++;
                        default: n_closed++;
                    endcase
                    if (got.kind != want.kind) report("kind", got.kind, want.kind);
                    if (got.qubit != want.qubit) report("qubit", got.qubit, want.qubit);
                    if (got.pulse != want.pulse) report("pulse", got.pulse, want.pulse);
                    if (got.succeeded != want.succeeded)
                        report("succeeded", got.succeeded, want.succeeded);
                    if (got.freed_count != want.freed_count)
                        report("freed_count", got.freed_count, want.freed_count);
                    if (got.trial_now != want.trial_now)
                        report("trial_now", got.trial_now, want.trial_now);
                    if (got.status != want.status) report("status", got.status, want.status);
                end
            end
            if (rcv_hold > 0) begin
                rcv_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // one well-formed burst with random content
    task automatic run_burst(input int q, input int len);
        int nres;
        int tr;
        for (int i = 0; i < len; i++) begin
            tr = ($urandom_range(9) == 0) ? $urandom : trial_q[q];
            send_item(mk_item(FUNC_SHOOT, q, tr, i == 0, $urandom, $urandom, $urandom));
        end
        nres = $urandom_range(0, len);
        for (int i = 0; i < nres; i++)
            send_item(mk_item(FUNC_RESULT, q, $urandom, $urandom,
                              ($urandom_range(7) == 0) ? $urandom_range(63) : i,
                              $urandom, $urandom));
        send_item(mk_item(FUNC_CLOSE, q, $urandom, $urandom, $urandom, $urandom,
                          ($urandom_range(4) == 0) ? $urandom_range(64) : nres));
    endtask

    task automatic test_directed();
        write_usable(64);
        // begin, middle, double free, kept, unlogged, close, missing shots
        send_item(mk_item(FUNC_SHOOT, 0, 0, 1, 0, 0, 0));
        send_item(mk_item(FUNC_SHOOT, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(FUNC_RESULT, 0, 0, 0, 0, 1, 0));
        send_item(mk_item(FUNC_RESULT, 0, 0, 0, 0, 1, 0));
        send_item(mk_item(FUNC_RESULT, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(FUNC_RESULT, 0, 0, 0, 63, 1, 0));
        send_item(mk_item(FUNC_CLOSE, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(FUNC_CLOSE, 0, 0, 0, 0, 0, 64));
        // stale trial and unused func
        send_item(mk_item(FUNC_SHOOT, 0, 16'hFFFF, 1, 0, 0, 0));
        send_item(mk_item(2'd3, 0, 16'hFFFF, 1, 63, 1, 127));
        drain();
        // single usable qubit: first and last, then none free
        write_usable(1);
        send_item(mk_item(FUNC_SHOOT, 2, trial_q[2], 1, 0, 0, 0));
        send_item(mk_item(FUNC_SHOOT, 2, trial_q[2], 0, 0, 0, 0));
        send_item(mk_item(FUNC_CLOSE, 2, 0, 0, 0, 0, 0));
        send_item(mk_item(FUNC_SHOOT, 2, trial_q[2], 0, 0, 0, 0));
        drain();
        // nothing usable
        write_usable(0);
        send_item(mk_item(FUNC_SHOOT, 3, 0, 1, 0, 0, 0));
        send_item(mk_item(FUNC_CLOSE, 3, 0, 0, 0, 0, 0));
        drain();
        // above range counts as all qubits; fill the log, free one, shoot into a full log
        write_usable(127);
        for (int i = 0; i < 64; i++)
            send_item(mk_item(FUNC_SHOOT, 1, 0, i == 0, 0, 0, 0));
        send_item(mk_item(FUNC_RESULT, 1, 0, 0, 10, 1, 0));
        send_item(mk_item(FUNC_SHOOT, 1, 0, 0, 0, 0, 0));
        send_item(mk_item(FUNC_CLOSE, 1, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_random(input int n_items, input int s_idle, input int r_idle);
        int goal;
        int cfg_pick;
        snd_idle_pct = s_idle;
        rcv_idle_pct = r_idle;
        goal = sent_items + n_items;
        while (sent_items < goal) begin
            cfg_pick = $urandom_range(9);
            write_usable(cfg_pick == 0 ? 0 : cfg_pick == 1 ? 127 :
                         cfg_pick == 2 ? 64 : $urandom_range(1, 64));
            repeat (10) begin
                if ($urandom_range(99) < 85)
                    run_burst($urandom_range(NQ - 1),
                              ($urandom_range(19) == 0) ? $urandom_range(1, 64)
                                                        : $urandom_range(1, 8));
                else
                    send_item(t_in_item'({$urandom, $urandom}));
            end
            drain();
        end
    endtask

    // long receiver stall while the sender keeps offering items
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_usable(64);
        rcv_hold = 400;
        for (int i = 0; i < 6; i++) run_burst(i, 5);
        drain();
    endtask

    initial begin
        errors = 0; sent_items = 0; rcv_hold = 0;
        n_emit = 0; n_handled = 0; n_closed = 0; n_dropped = 0;
        snd_idle_pct = 0; rcv_idle_pct = 0;
        usable_cfg = 64;
        for (int q = 0; q < NQ; q++) begin
            busy_q[q] = '0; trial_q[q] = '0; shots_q[q] = 0;
        end
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500, 26, 46);
        test_random(500, 46, 26);
        test_backpressure();
        test_random(500, 0, 0);

        $display("covered %0d items: %0d emissions, %0d results handled, %0d closes, %0d dropped",
                 sent_items, n_emit, n_handled, n_closed, n_dropped);
        $display("register settings from 0 to 127, full shot log, long output stall");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/qba_pkg.sv
rtl/core/qba_if.sv
rtl/core/qba_front.sv
rtl/core/qba_back.sv
rtl/core/qubit_burst_allocator_core.sv
rtl/core/qba_checker.sv
tb/sv/qubit_burst_allocator_core_tb.sv
